[rtl/core/hbe_pkg.sv]
// ----------------------------------------------------------------------------
// hbe_pkg
// Types and constants for the histogram bucket estimator.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int MaxBuckets     = 256;
  localparam int WordsPerBucket = 18;
  localparam int BktW           = 8;
  localparam int AddrW          = 13;
  localparam int CntW           = 9;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ALL   = 3'd1,
    OP_KEY1  = 3'd2,
    OP_KEY2  = 3'd3,
    OP_KEY3  = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  bucket_index;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [31:0] key_third;
  } hbe_in_t;

  typedef struct packed {
    logic [4:0]  out_word_index;
    logic [31:0] out_word;
    logic        found;
    logic        last;
  } hbe_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ALL_SUM,     // issue reads of words 6..17 per bucket
    ST_ALL_B0,      // bounds reads
    ST_SRCH_RD0,
    ST_SRCH_RD3,
    ST_SRCH_CMP,
    ST_LEFT_RD,
    ST_LEFT_CMP,
    ST_RIGHT_RD,
    ST_RIGHT_CMP,
    ST_SUM,
    ST_SUM_WAIT,
    ST_DIV,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        go;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  // address of word w of bucket b
  function automatic logic [AddrW-1:0] word_addr(input logic [BktW:0] b,
                                                 input logic [4:0] w);
    logic [AddrW-1:0] a;
    a = AddrW'(b[BktW-1:0]) * AddrW'(WordsPerBucket) + AddrW'(w);
    return a;
  endfunction

endpackage

[rtl/core/hbe_ceil_div.sv]
// ----------------------------------------------------------------------------
// hbe_ceil_div
// Radix-2 restoring divider computing ceil(num/den), one bit per cycle.
// ----------------------------------------------------------------------------
module hbe_ceil_div import hbe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [32:0] dividend;
  logic [32:0] quo;
  logic [32:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;

  assign trial = {rem[32:0], dividend[32]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        if (req.den == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 6'd33;
        end
      end else if (busy) begin
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      // ceil(x/d) = floor((x + d - 1)/d), 33-bit numerator
      dividend <= {1'b0, req.num} + {1'b0, req.den} - 33'd1;
      den      <= req.den;
      rem      <= '0;
      // zero divisor: answer all ones at once
      quo      <= (req.den == '0) ? {1'b0, AllOnes} : '0;
    end else if (busy) begin
      dividend <= {dividend[31:0], 1'b0};
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= {rem[31:0], dividend[32]};
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo[31:0];

endmodule

[rtl/core/histogram_bucket_estimator.sv]
// ----------------------------------------------------------------------------
// histogram_bucket_estimator
// Bucket table in one synchronous RAM with query sequencer and divider.
// ----------------------------------------------------------------------------
//  channel   | signals                        | handshake
//  ----------+--------------------------------+---------------------------
//  command   | start, busy, cmd               | taken when start && !busy
//  result    | result_valid, result           | one word per cycle, no stall
//  config    | cfg_we, cfg_wdata              | written when cfg_we
//
//  A load writes one table word without leaving idle. A query reads the table
//  through one RAM port: the binary search, the neighbor walk a bucket at a
//  time, the sum 12 reads a bucket, then one ceiling division for each count
//  word past the prefix counts in use (nine to eleven) and 18 output words.
//  The RAM port and the divider set the latency.
//  Reset clears control state and bucket_count; table contents are undefined.
module histogram_bucket_estimator import hbe_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  hbe_in_t         cmd,
  input  logic            cfg_we,
  input  logic [CntW-1:0] cfg_wdata,
  output logic            result_valid,
  output hbe_out_t        result
);

  logic [31:0] mem [MaxBuckets*WordsPerBucket];
  logic [31:0] rdata;
  logic [AddrW-1:0] raddr;
  logic        we;
  logic [AddrW-1:0] waddr;

  logic [CntW-1:0] bucket_count;
  logic [CntW-1:0] cnt;
  state_t state, state_next;

  logic [2:0]  op;
  logic [31:0] key1, key2, key3;
  logic [31:0] acc [WordsPerBucket];
  logic        found;
  logic [CntW-1:0] lo, hi, mid, s_idx, e_idx, cur;
  logic [4:0]  wsel, wsel_d;
  logic [31:0] lo_key;
  logic        rd_pend;
  logic [4:0]  emit_idx;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [1:0]  nkeys;

  assign cnt = (bucket_count > CntW'(MaxBuckets)) ? CntW'(MaxBuckets) : bucket_count;
  assign nkeys = 2'(op - 3'd1);
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) bucket_count <= '0;
    else if (cfg_we) bucket_count <= cfg_wdata;
  end

  assign we = start && !busy && cmd.opcode == OP_LOAD && cmd.word_index < 5'd18;
  assign waddr = word_addr({1'b0, cmd.bucket_index}, cmd.word_index);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= cmd.word_value;
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr = '0;
    unique case (state)
      ST_SRCH_RD0:  raddr = word_addr(mid, 5'd0);
      ST_SRCH_RD3:  raddr = word_addr(mid, 5'd3);
      ST_LEFT_RD:   raddr = word_addr(s_idx - CntW'(1), 5'd3);
      ST_RIGHT_RD:  raddr = word_addr(e_idx, 5'd0);
      ST_ALL_SUM, ST_SUM, ST_ALL_B0: raddr = word_addr(cur, wsel);
      default:      raddr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) begin
        if (cmd.opcode == OP_ALL) state_next = ST_ALL_SUM;
        else if (cmd.opcode == OP_KEY1 || cmd.opcode == OP_KEY2 ||
                 cmd.opcode == OP_KEY3) state_next = ST_SRCH_RD0;
      end
      ST_ALL_SUM, ST_SUM: if (cur >= hi && !rd_pend) state_next = ST_ALL_B0;
      ST_ALL_B0:   if (wsel == 5'd6 && !rd_pend)
                     state_next = (op == OP_ALL) ? ST_EMIT : ST_DIV;
      ST_SRCH_RD0: state_next = (lo < hi) ? ST_SRCH_RD3 : ST_SRCH_CMP;
      ST_SRCH_RD3: state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (lo >= hi) state_next = (lo >= cnt) ? ST_EMIT : ST_LEFT_RD;
        else state_next = ST_SRCH_RD0;
      end
      ST_LEFT_RD:  state_next = (s_idx == '0) ? ST_RIGHT_RD : ST_LEFT_CMP;
      ST_LEFT_CMP: state_next = (rdata > key1) ? ST_LEFT_RD : ST_RIGHT_RD;
      ST_RIGHT_RD: state_next = (e_idx >= cnt) ? ST_SUM : ST_RIGHT_CMP;
      ST_RIGHT_CMP: state_next = (rdata <= key1) ? ST_RIGHT_RD : ST_SUM;
      ST_DIV:      state_next = ST_DIV_RUN;
      ST_DIV_RUN:  if (drsp.done) state_next = (wsel == 5'd17) ? ST_EMIT : ST_DIV;
      ST_EMIT:     if (emit_idx == 5'd17) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign dreq.go  = (state == ST_DIV);
  assign dreq.num = acc[wsel];
  assign dreq.den = acc[5'd5 + 5'(nkeys)];

  hbe_ceil_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // datapath
  always_ff @(posedge clk) begin
    rd_pend <= 1'b0;
    wsel_d  <= wsel;
    unique case (state)
      ST_IDLE: if (start) begin
        op <= cmd.opcode; key1 <= cmd.key_first;
        key2 <= cmd.key_second; key3 <= cmd.key_third;
        found <= 1'b1; emit_idx <= '0;
        lo <= '0; hi <= cnt; mid <= cnt >> 1; cur <= '0; wsel <= 5'd6;
        for (int i = 0; i < WordsPerBucket; i++) acc[i] <= '0;
        if (cmd.opcode == OP_ALL) begin
          acc[3] <= AllOnes; acc[4] <= AllOnes; acc[5] <= AllOnes;
        end
      end
      ST_ALL_SUM, ST_SUM: begin
        if (rd_pend) acc[wsel_d] <= acc[wsel_d] + rdata;
        if (cur < hi) begin
          rd_pend <= 1'b1;
          if (wsel == 5'd17) begin
            wsel <= 5'd6; cur <= cur + CntW'(1);
          end else wsel <= wsel + 5'd1;
        end
        if (cur >= hi && !rd_pend) begin
          // bounds: words 0..2 of lo, words 3..5 of hi-1
          wsel <= 5'd0; cur <= lo;
          rd_pend <= 1'b0;
        end
      end
      ST_ALL_B0: begin
        if (lo < hi) begin
          if (rd_pend) acc[wsel_d] <= rdata;
          if (wsel != 5'd6) begin
            rd_pend <= 1'b1;
            wsel <= wsel + 5'd1;
            if (wsel == 5'd2) cur <= hi - CntW'(1);
          end
        end else wsel <= 5'd6;
        if (wsel == 5'd6 && !rd_pend) wsel <= 5'd6;
      end
      ST_SRCH_RD0: mid <= (lo + hi) >> 1;
      ST_SRCH_RD3: lo_key <= rdata;
      ST_SRCH_CMP: begin
        if (lo < hi) begin
          if (lo_key <= key1 && key1 <= rdata) hi <= mid;
          else if (key1 < lo_key) hi <= mid;
          else lo <= mid + CntW'(1);
          if (lo_key <= key1 && key1 <= rdata) lo <= mid;
          mid <= (lo_key <= key1 && key1 <= rdata) ? mid :
                 (key1 < lo_key) ? ((lo + mid) >> 1) : ((mid + CntW'(1) + hi) >> 1);
        end else begin
          if (lo >= cnt) found <= 1'b0;
          s_idx <= lo + CntW'(1); e_idx <= lo + CntW'(1);
        end
      end
      ST_LEFT_CMP: if (rdata > key1) s_idx <= s_idx - CntW'(1);
      ST_RIGHT_CMP: if (rdata <= key1) e_idx <= e_idx + CntW'(1);
      default: ;
    endcase
    if (state == ST_RIGHT_RD && e_idx >= cnt || state == ST_RIGHT_CMP && rdata > key1) begin
      lo <= s_idx; hi <= e_idx; cur <= s_idx; wsel <= 5'd6; rd_pend <= 1'b0;
      // an empty neighbor range is a miss
      found <= (s_idx != e_idx);
    end
    if (state == ST_ALL_B0 && wsel == 5'd6 && !rd_pend)
      wsel <= 5'd6 + 5'(nkeys);
    if (state == ST_DIV_RUN && drsp.done) begin
      acc[wsel] <= drsp.quo;
      wsel <= wsel + 5'd1;
    end
    if (state == ST_EMIT) emit_idx <= emit_idx + 5'd1;
  end

  // final word selection: bounds and prefix words for keyed queries
  logic [31:0] out_val;
  always_comb begin
    out_val = acc[emit_idx];
    if (op != OP_ALL) begin
      unique case (emit_idx)
        5'd0: out_val = key1;
        5'd1: out_val = (nkeys >= 2'd2) ? key2 : '0;
        5'd2: out_val = (nkeys == 2'd3) ? key3 : '0;
        5'd3: out_val = key1;
        5'd4: out_val = (nkeys >= 2'd2) ? key2 : AllOnes;
        5'd5: out_val = (nkeys == 2'd3) ? key3 : AllOnes;
        default: begin
          if (!found) out_val = '0;
          else if (emit_idx <= 5'd5 + 5'(nkeys)) out_val = 32'd1;
        end
      endcase
    end
  end

  assign result_valid = (state == ST_EMIT);
  assign result.out_word_index = emit_idx;
  assign result.out_word = out_val;
  assign result.found = found;
  assign result.last = (emit_idx == 5'd17);

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !busy) else $error("last did not end query");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside query");
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid &&
    result.out_word_index == $past(result.out_word_index) + 5'd1)
    else $error("result index gap");

endmodule
